>>> rtl/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

  // Sieve capacity.
  localparam int MAX_LIMIT  = 65535;
  localparam int MAX_PRIMES = 8192;

  // Field widths of the stream items.
  localparam int LIMIT_W = 16;
  localparam int INDEX_W = 13;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 14;

  localparam int IN_DATA_W  = ((LIMIT_W + INDEX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // Internal widths derived from the capacity.
  localparam int MAP_DEPTH = MAX_LIMIT + 1;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int PIDX_W    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int TOT_W     = $clog2(MAX_PRIMES + 1);
  localparam int PROD_W    = 2 * MAP_AW;

  // Command codes carried in the input tuser.
  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic start_run;
    logic start_read;
    logic map_rd;
    logic map_chk;
    logic pl_rd;
    logic mul;
    logic mark;
    logic next_i;
    logic clr_wr;
    logic load_run_res;
    logic load_read_res;
  } lps_cmd_t;

  typedef struct packed {
    logic lim_small;
    logic i_last;
    logic is_prime;
    logic list_full;
    logic prod_over;
    logic j_is_lpf;
    logic out_free;
  } lps_stat_t;

endpackage

>>> rtl/lps_ctrl.sv
`timescale 1ns / 1ps

module lps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  output lps_pkg::lps_cmd_t cmd,
  input  lps_pkg::lps_stat_t stat
);
  import lps_pkg::*;

  typedef enum logic [10:0] {
    ST_INIT      = 11'b000_0000_0001,
    ST_IDLE      = 11'b000_0000_0010,
    ST_START     = 11'b000_0000_0100,
    ST_RD        = 11'b000_0000_1000,
    ST_CHK       = 11'b000_0001_0000,
    ST_PRD       = 11'b000_0010_0000,
    ST_MUL       = 11'b000_0100_0000,
    ST_MARK      = 11'b000_1000_0000,
    ST_SWEEP     = 11'b001_0000_0000,
    ST_DONE_RUN  = 11'b010_0000_0000,
    ST_DONE_READ = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (stat.i_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_RUN) begin
            cmd.start_run = 1'b1;
            state_next    = ST_START;
          end else begin
            cmd.start_read = 1'b1;
            state_next     = ST_DONE_READ;
          end
        end
      end
      ST_START: begin
        state_next = stat.lim_small ? ST_DONE_RUN : ST_RD;
      end
      ST_RD: begin
        cmd.map_rd = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        // A new prime with no room left ends the run; the rest of the map
        // still has to be swept clean.
        if (stat.is_prime && stat.list_full) begin
          state_next = ST_SWEEP;
        end else begin
          cmd.map_chk = 1'b1;
          state_next  = ST_PRD;
        end
      end
      ST_PRD: begin
        cmd.pl_rd  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MARK;
      end
      ST_MARK: begin
        cmd.mark = !stat.prod_over;
        if (stat.prod_over || stat.j_is_lpf) begin
          if (stat.i_last) begin
            state_next = ST_DONE_RUN;
          end else begin
            cmd.next_i = 1'b1;
            state_next = ST_RD;
          end
        end else begin
          state_next = ST_PRD;
        end
      end
      ST_SWEEP: begin
        cmd.clr_wr = 1'b1;
        if (stat.i_last) begin
          state_next = ST_DONE_RUN;
        end
      end
      ST_DONE_RUN: begin
        if (stat.out_free) begin
          cmd.load_run_res = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_DONE_READ: begin
        if (stat.out_free) begin
          cmd.load_read_res = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

>>> rtl/lps_dp.sv
`timescale 1ns / 1ps

module lps_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lps_pkg::lps_cmd_t             cmd,
  output lps_pkg::lps_stat_t            stat,
  input  logic [lps_pkg::LIMIT_W-1:0]   in_limit,
  input  logic [lps_pkg::INDEX_W-1:0]   in_index,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lps_pkg::VALUE_W-1:0]   out_value,
  output logic [lps_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_flag
);
  import lps_pkg::*;

  // Each map entry holds a mark bit and the list index of the smallest
  // prime factor, which stands in for the divisibility test of the sieve.
  logic [PIDX_W:0]       map_mem [MAP_DEPTH];
  logic [MAP_AW-1:0]     pl_mem  [MAX_PRIMES];

  logic [MAP_AW-1:0]     i;
  logic [MAP_AW-1:0]     lim;
  logic [TOT_W-1:0]      total;
  logic [PIDX_W-1:0]     j;
  logic [PIDX_W-1:0]     lpf;
  logic [PROD_W-1:0]     prod;
  logic [PIDX_W:0]       map_q;
  logic [MAP_AW-1:0]     pl_q;
  logic [INDEX_W-1:0]    idx;

  logic                  map_we;
  logic [MAP_AW-1:0]     map_waddr;
  logic [PIDX_W:0]       map_wdata;
  logic                  pl_we;
  logic                  pl_re;
  logic [PIDX_W-1:0]     pl_raddr;
  logic                  read_hit;

  always_comb begin
    stat.lim_small = (lim < MAP_AW'(2));
    stat.i_last    = (i == lim);
    stat.is_prime  = !map_q[PIDX_W];
    stat.list_full = (total >= TOT_W'(MAX_PRIMES));
    stat.prod_over = (prod > PROD_W'(lim));
    stat.j_is_lpf  = (j == lpf);
    stat.out_free  = !out_valid || out_ready;
  end

  // Visited entries are written back to zero, so the map is clean again
  // for the next run without a separate pass.
  always_comb begin
    map_we    = cmd.map_chk || cmd.mark || cmd.clr_wr;
    map_waddr = cmd.mark ? prod[MAP_AW-1:0] : i;
    map_wdata = cmd.mark ? {1'b1, j} : '0;
    pl_we     = cmd.map_chk && stat.is_prime;
    pl_re     = cmd.start_read || cmd.pl_rd;
    pl_raddr  = cmd.start_read ? PIDX_W'(in_index) : j;
    read_hit  = (TOT_W'(idx) < total);
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd.map_rd) begin
      map_q <= map_mem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[total[PIDX_W-1:0]] <= i;
    end
    if (pl_re) begin
      pl_q <= pl_mem[pl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      lim       <= MAP_AW'(MAX_LIMIT);
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start_run) begin
        i     <= MAP_AW'(2);
        total <= '0;
        if (32'(in_limit) > MAX_LIMIT) begin
          lim <= MAP_AW'(MAX_LIMIT);
        end else begin
          lim <= MAP_AW'(in_limit);
        end
      end else if (cmd.next_i || cmd.clr_wr) begin
        i <= i + MAP_AW'(1);
      end
      if (pl_we) begin
        total <= total + TOT_W'(1);
      end
      if (cmd.load_run_res || cmd.load_read_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      idx <= in_index;
    end
    if (cmd.map_chk) begin
      j <= '0;
      if (stat.is_prime) begin
        lpf <= total[PIDX_W-1:0];
      end else begin
        lpf <= map_q[PIDX_W-1:0];
      end
    end else if (cmd.mark) begin
      j <= j + PIDX_W'(1);
    end
    if (cmd.mul) begin
      prod <= PROD_W'(i) * PROD_W'(pl_q);
    end
    if (cmd.load_run_res) begin
      out_value <= '0;
      out_count <= COUNT_W'(total);
      out_flag  <= 1'b1;
    end else if (cmd.load_read_res) begin
      out_value <= read_hit ? VALUE_W'(pl_q) : '0;
      out_count <= COUNT_W'(total);
      out_flag  <= read_hit;
    end
  end

endmodule

>>> rtl/linear_prime_sieve.sv
// Read beat: the prime list is read on acceptance; the result is registered once the output is free.
// Run beat: each number from 2 to limit is read and checked in the map, and each product tried
// takes a read of the prime list, a registered multiply and a mark.
// One beat is worked on at a time; a new beat is taken while a result waits.
// Reset is synchronous; after it a clearing pass writes all MAX_LIMIT+1 entries (65536) of
// the composite map to zero with s_axis_tready low.
`timescale 1ns / 1ps

module linear_prime_sieve (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lps_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // limit, index, zero fill
  input  logic [0:0]                       s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // prime_value, prime_count, zero fill
  output logic [0:0]                       m_axis_tuser   // valid_res
);
  import lps_pkg::*;

  lps_cmd_t            cmd;
  lps_stat_t           stat;
  logic [VALUE_W-1:0]  out_value;
  logic [COUNT_W-1:0]  out_count;
  logic                out_flag;

  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_limit  (s_axis_tdata[LIMIT_W-1:0]),
    .in_index  (s_axis_tdata[LIMIT_W+INDEX_W-1:LIMIT_W]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_value (out_value),
    .out_count (out_count),
    .out_flag  (out_flag)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_count, out_value});
  assign m_axis_tuser = out_flag;

endmodule

>>> rtl/lps_checker.sv
`timescale 1ns / 1ps

module lps_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [lps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic [0:0]                       m_axis_tuser
);
  import lps_pkg::*;

  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] count;

  assign value = m_axis_tdata[VALUE_W-1:0];
  assign count = m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_init_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input open during clearing pass");

  // Only one beat is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // A nonzero value comes only from a valid read and is at least 2.
  a_value_prime: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (value != '0) |-> m_axis_tuser[0] && (value >= VALUE_W'(2)))
    else $error("bad prime value in result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(count) <= MAX_PRIMES))
    else $error("prime count out of range");

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (.*);
